// File: rtl/pcps_pkg.sv
// Package with payload types, codes and default sizes for the point charge potential block.
package pcps_pkg;

  localparam int DEF_MAX_CHARGES = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam int POT_W = 48;
  localparam int THR_W = 47;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ON_CHARGE = 2'd2;

  localparam logic REG_CLIP_ENABLE = 1'b0;
  localparam logic REG_CLIP_THRESHOLD = 1'b1;

  typedef struct packed {
    logic operation;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] charge;
  } in_item_t;

  typedef struct packed {
    logic signed [POT_W-1:0] potential;
    logic clipped;
    logic [1:0] status;
  } out_item_t;

endpackage

// File: rtl/point_charge_potential_sum_top.sv
// Top level of the point charge potential block: charge memory, root and divide sequencer.
// Append items write one charge into the memory, or report ST_FULL when it is full. A query walks
// the stored charges one at a time: per charge a memory read, a squaring step, an add, the
// bit-serial square root, the bit-serial divider and an accumulate step. A charge at the query
// position skips the divider.
// One item is in work at a time; a finished result waits in the output register.
module point_charge_potential_sum_top
  import pcps_pkg::*;
#(
  parameter int MAX_CHARGES = DEF_MAX_CHARGES,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output out_item_t out_item,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int IW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
  localparam int CW = $clog2(MAX_CHARGES + 1);
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int SW = $clog2(NUM_W + 34);
  localparam logic signed [POT_W:0] POT_MAX = {2'b00, {(POT_W-1){1'b1}}};
  localparam logic signed [POT_W:0] POT_MIN = {2'b11, {(POT_W-1){1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_SQ   = 8'b00000100,
    S_ADD  = 8'b00001000,
    S_SQRT = 8'b00010000,
    S_DIV  = 8'b00100000,
    S_ACC  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state;
  logic [95:0] mem [MAX_CHARGES];
  logic [95:0] rd_data;
  logic [CW-1:0] count, k;
  logic clip_enable;
  logic [THR_W-1:0] clip_threshold;
  logic signed [31:0] px, py, cq;
  logic [65:0] sx, sy, d2;
  logic d2_zero;
  logic [33:0] rem;
  logic [32:0] root;
  logic [32:0] dr;
  logic [NUM_W-1:0] num;
  logic [SW-1:0] step;
  logic signed [POT_W-1:0] acc;
  logic sat;
  logic [1:0] status;

  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  logic [35:0] rem_t, trial;
  logic [33:0] dr_t;
  logic [31:0] qmag;
  logic [63:0] m;
  logic signed [POT_W:0] term, sum, sum_sat;
  logic term_sat, sum_ovf;
  logic [POT_W-1:0] acc_mag;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    dx = 33'(px) - 33'(signed'(rd_data[95:64]));
    dy = 33'(py) - 33'(signed'(rd_data[63:32]));
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    rem_t = {rem[33:0], d2[65:64]};
    trial = {1'b0, root, 2'b01};
    dr_t = {dr, num[NUM_W-1]};
    qmag = cq[31] ? 32'(-33'(cq)) : 32'(cq);
    m = 64'(num);
    term_sat = 1'b0;
    if (d2_zero) begin
      if (cq > 0) begin
        term = POT_MAX;
        term_sat = 1'b1;
      end else if (cq < 0) begin
        term = POT_MIN;
        term_sat = 1'b1;
      end else begin
        term = '0;
      end
    end else if (cq < 0) begin
      if (m > 64'(1) << (POT_W - 1)) begin
        term = POT_MIN;
        term_sat = 1'b1;
      end else begin
        term = -(POT_W+1)'(signed'({1'b0, m[POT_W-1:0]}));
      end
    end else begin
      if (m > 64'(POT_MAX)) begin
        term = POT_MAX;
        term_sat = 1'b1;
      end else begin
        term = (POT_W+1)'(signed'({1'b0, m[POT_W-1:0]}));
      end
    end
    sum = (POT_W+1)'(acc) + term;
    sum_ovf = 1'b0;
    if (sum > POT_MAX) begin
      sum_sat = POT_MAX;
      sum_ovf = 1'b1;
    end else if (sum < POT_MIN) begin
      sum_sat = POT_MIN;
      sum_ovf = 1'b1;
    end else begin
      sum_sat = sum;
    end
    acc_mag = acc[POT_W-1] ? POT_W'(-acc) : POT_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_item.operation == OP_APPEND && count < CW'(MAX_CHARGES))
    begin
      mem[count[IW-1:0]] <= {in_item.x, in_item.y, in_item.charge};
    end
    rd_data <= mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      clip_enable <= 1'b0;
      clip_threshold <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLIP_ENABLE: clip_enable <= cfg_data[0];
          default: clip_threshold <= cfg_data;
        endcase
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px <= in_item.x;
            py <= in_item.y;
            acc <= '0;
            sat <= 1'b0;
            status <= ST_OK;
            k <= '0;
            if (in_item.operation == OP_APPEND) begin
              if (count < CW'(MAX_CHARGES)) count <= count + 1'b1;
              else status <= ST_FULL;
              state <= S_DONE;
            end else begin
              state <= (count == '0) ? S_DONE : S_RD;
            end
          end
        end
        S_RD: state <= S_SQ;
        S_SQ: begin
          sx <= ax * ax;
          sy <= ay * ay;
          cq <= signed'(rd_data[31:0]);
          state <= S_ADD;
        end
        S_ADD: begin
          d2 <= sx + sy;
          d2_zero <= ((sx | sy) == '0);
          rem <= '0;
          root <= '0;
          step <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_t >= trial) begin
            rem <= 34'(rem_t - trial);
            root <= {root[31:0], 1'b1};
          end else begin
            rem <= rem_t[33:0];
            root <= {root[31:0], 1'b0};
          end
          d2 <= {d2[63:0], 2'b00};
          step <= step + 1'b1;
          if (step == SW'(32)) begin
            step <= '0;
            dr <= '0;
            num <= {qmag, {FRAC_BITS{1'b0}}};
            state <= d2_zero ? S_ACC : S_DIV;
          end
        end
        S_DIV: begin
          if (dr_t >= {1'b0, root}) begin
            dr <= 33'(dr_t - {1'b0, root});
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            dr <= dr_t[32:0];
            num <= {num[NUM_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == SW'(NUM_W - 1)) state <= S_ACC;
        end
        S_ACC: begin
          acc <= sum_sat[POT_W-1:0];
          if (term_sat || sum_ovf) sat <= 1'b1;
          if (d2_zero) status <= ST_ON_CHARGE;
          k <= k + 1'b1;
          state <= (k + 1'b1 == count) ? S_DONE : S_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item.status <= status;
            if (clip_enable && acc_mag > POT_W'(clip_threshold)) begin
              out_item.potential <= acc[POT_W-1] ? -POT_W'(clip_threshold)
                                                 : POT_W'(clip_threshold);
              out_item.clipped <= 1'b1;
            end else begin
              out_item.potential <= acc;
              out_item.clipped <= sat;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
